@@ sv/flt_pkg.sv @@
`default_nettype none

package flt_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    localparam logic [1:0] OP_FAILED   = 2'd0;
    localparam logic [1:0] OP_ACCEPTED = 2'd1;

    localparam logic [1:0] ST_FAILED       = 2'd0;
    localparam logic [1:0] ST_CONNECTED    = 2'd1;
    localparam logic [1:0] ST_DISCONNECTED = 2'd2;
    localparam logic [1:0] ST_BLOCKED      = 2'd3;

    localparam logic [7:0] ALLOWED_RESET = 8'd3;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] attempt_count;
        logic       block_request;
        logic       new_entry;
        logic       table_full;
    } result_t;

endpackage

`default_nettype wire

@@ sv/flt_engine.sv @@
`default_nettype none

module flt_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    output logic                  idle,
    input  wire logic [31:0]      source_ip,
    input  wire logic [1:0]       opcode,
    input  wire logic [7:0]       attempt_limit,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output flt_pkg::result_t      res
);
    import flt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [31:0] addr_mem [TABLE_DEPTH];
    logic [7:0]  cnt_mem  [TABLE_DEPTH];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [31:0]      ip_reg;
    logic [1:0]       op_reg;
    result_t          res_reg, res_next;

    logic [31:0]      addr_q;
    logic [7:0]       cnt_q;
    logic             rd_en;
    logic             addr_we;
    logic             cnt_we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       cnt_wdata;
    logic [7:0]       count_new;
    logic [1:0]       op_status;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            addr_q <= addr_mem[rd_idx_next];
            cnt_q  <= cnt_mem[rd_idx_next];
        end
        if (addr_we) begin
            addr_mem[waddr] <= ip_reg;
        end
        if (cnt_we) begin
            cnt_mem[waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg  <= issue_next;
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
        if (start) begin
            ip_reg <= source_ip;
            op_reg <= opcode;
        end
    end

    always_comb begin
        case (op_reg)
            OP_FAILED:   count_new = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 8'd1;
            OP_ACCEPTED: count_new = 8'd0;
            default:     count_new = cnt_q;
        endcase
        case (op_reg)
            OP_FAILED:   op_status = ST_FAILED;
            OP_ACCEPTED: op_status = ST_CONNECTED;
            default:     op_status = ST_DISCONNECTED;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        used_next     = used_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        res_next      = res_reg;
        rd_en         = 1'b0;
        addr_we       = 1'b0;
        cnt_we        = 1'b0;
        waddr         = rd_idx_reg;
        cnt_wdata     = count_new;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    issue_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (rd_valid_reg && (addr_q == ip_reg)) begin
                    cnt_we                 = 1'b1;
                    res_next.attempt_count = count_new;
                    res_next.new_entry     = 1'b0;
                    res_next.table_full    = 1'b0;
                    if (count_new > attempt_limit) begin
                        res_next.status        = ST_BLOCKED;
                        res_next.block_request = 1'b1;
                    end else begin
                        res_next.status        = op_status;
                        res_next.block_request = 1'b0;
                    end
                    state_next = S_DONE;
                end else if (issue_reg < used_reg) begin
                    rd_en         = 1'b1;
                    rd_idx_next   = issue_reg[IDX_W-1:0];
                    rd_valid_next = 1'b1;
                    issue_next    = issue_reg + CNT_W'(1);
                end else if (!rd_valid_reg) begin
                    res_next.status        = op_status;
                    res_next.block_request = 1'b0;
                    if (used_reg < CNT_W'(TABLE_DEPTH)) begin
                        waddr                  = used_reg[IDX_W-1:0];
                        addr_we                = 1'b1;
                        cnt_we                 = 1'b1;
                        cnt_wdata              = 8'd1;
                        used_next              = used_reg + CNT_W'(1);
                        res_next.attempt_count = 8'd1;
                        res_next.new_entry     = 1'b1;
                        res_next.table_full    = 1'b0;
                    end else begin
                        res_next.attempt_count = 8'd0;
                        res_next.new_entry     = 1'b0;
                        res_next.table_full    = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ sv/failed_login_tracker_unit.sv @@
// Channel   Direction  tdata               tuser
// s_        in         [31:0] source_ip    [1:0] opcode
// m_        out        [7:0] attempt_count [1:0] status, [2] block_request,
//                                          [3] new_entry, [4] table_full
//
// An event holds s_tready low for the whole lookup: the lookup reads one stored
// address per cycle from the address memory, so a hit in slot i ends the scan
// there, a miss reads every used slot, and an event on an empty table reads none.
// Reset empties the table at once and sets the attempt limit to 3.
// The result sits in an output register; a stalled m_ side holds the next
// event in its final cycle until the register frees.
`default_nettype none

module failed_login_tracker_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] source_ip
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] attempt_count
    output logic [4:0]       m_tuser    // [1:0] status, [2] block_request,
                                        // [3] new_entry, [4] table_full
);
    import flt_pkg::*;

    logic [7:0] allowed_reg;
    logic       m_valid_reg;
    result_t    m_res_reg;
    logic       eng_idle;
    logic       res_valid;
    logic       res_ready;
    result_t    res;

    assign res_ready = !m_valid_reg || m_tready;
    assign s_tready  = eng_idle;

    flt_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (s_tvalid && eng_idle),
        .idle            (eng_idle),
        .source_ip       (s_tdata),
        .opcode          (s_tuser),
        .attempt_limit   (allowed_reg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allowed_reg <= ALLOWED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                allowed_reg <= cfg_wdata;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.attempt_count;
    assign m_tuser  = {m_res_reg.table_full, m_res_reg.new_entry,
                       m_res_reg.block_request, m_res_reg.status};

endmodule

`default_nettype wire
